@@ rtl/core/dvrt_pkg.sv @@
`timescale 1ns / 1ps
package dvrt_pkg;
    localparam logic [4:0] COST_INF = 5'd16;
    localparam logic [7:0] AGE_MAX  = 8'd255;
    localparam logic [7:0] TIMEOUT_RESET = 8'd12;

    localparam logic [2:0] REQ_INSTALL   = 3'd0;
    localparam logic [2:0] REQ_MERGE     = 3'd1;
    localparam logic [2:0] REQ_TICK      = 3'd2;
    localparam logic [2:0] REQ_LOOKUP    = 3'd3;
    localparam logic [2:0] REQ_ADVERTISE = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] route_address;
        logic [4:0]  advertised_cost;
        logic [3:0]  hop_itf;
        logic        is_local;
    } t_req;

    typedef struct packed {
        logic [31:0] out_address;
        logic [4:0]  out_cost;
        logic [3:0]  out_interface;
        logic        found;
        logic        entry_valid;
        logic        table_changed;
        logic        table_full;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [31:0] address;
        logic [4:0]  cost;
        logic [3:0]  itf;
        logic [7:0]  age;
        logic        local_mark;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_APPEND,
        ST_OUT
    } t_state;
endpackage

@@ rtl/core/dvrt_mem.sv @@
`timescale 1ns / 1ps
module dvrt_mem #(
    parameter int MAX_ROUTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_ROUTES)-1:0] i_waddr,
    input  dvrt_pkg::t_entry              i_wdata,
    input  logic [$clog2(MAX_ROUTES)-1:0] i_raddr,
    output dvrt_pkg::t_entry              o_rdata
);
    import dvrt_pkg::*;

    t_entry r_mem [MAX_ROUTES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/distance_vector_route_table.sv @@
`timescale 1ns / 1ps
// distance-vector route table
// input channel i_req_valid/o_req_ready carries one request transaction
// (install, merge, tick, lookup, advertise); output channel
// o_rsp_valid/i_rsp_ready carries result transactions, last marks the end
// the table lives in one synchronous memory; a sequencer reads, modifies
// and writes back one entry at a time; one request is worked at a time
// each entry visited is read, then evaluated; install/merge stop on a hit,
// else append at the end (or report full); lookup stops on a hit of cost
// below COST_INF, tick walks all entries, an unknown request gives one result
// with no walk; advertise gives one result per entry, one for an empty table
// o_req_ready returns the cycle after the last result loads
// i_timeout_we writes r_timeout; only while idle, a rule the user keeps:
// the block itself does not enforce it
// reset: synchronous, active low; clears entry count, timeout back to 12;
// memory contents are not cleared, entries at or above the count are
// never evaluated
// a stalled receiver holds the result register; lookup and advertise walks wait on it
module distance_vector_route_table #(
    parameter int MAX_ROUTES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  dvrt_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output dvrt_pkg::t_rsp   o_rsp,
    input  logic             i_timeout_we,
    input  logic [7:0]       i_timeout_wdata
);
    import dvrt_pkg::*;

    localparam int AW = $clog2(MAX_ROUTES);
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ROUTES);

    t_state        r_state, n_state;
    t_req          r_req;
    logic [4:0]    r_cost;       // clamped cost
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;        // entry being visited
    logic [7:0]    r_timeout;
    logic          r_changed;
    t_rsp          r_rsp;
    t_rsp          n_rsp;
    logic          r_rsp_valid;

    logic          mem_we;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    dvrt_mem #(.MAX_ROUTES(MAX_ROUTES)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_idx[AW-1:0]),
        .i_wdata(mem_wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(mem_rdata)
    );

    // evaluation of the entry just read
    logic          hit;
    logic          at_end;
    logic          is_last_entry;
    logic [5:0]    c_plus;
    logic [7:0]    aged;
    t_entry        upd;
    logic          upd_we;
    logic          upd_chg;

    assign hit          = (mem_rdata.address == r_req.route_address);
    assign at_end       = (r_idx >= r_count);
    assign is_last_entry = (r_idx + CW'(1) == r_count);
    assign c_plus       = {1'b0, r_cost} + 6'd1;
    assign aged         = (mem_rdata.age < AGE_MAX) ? mem_rdata.age + 8'd1 : mem_rdata.age;

    always_comb begin
        upd     = mem_rdata;
        upd_we  = 1'b0;
        upd_chg = 1'b0;
        unique case (r_req.req_type)
            REQ_INSTALL: begin
                upd.cost       = r_cost;
                upd.itf        = r_req.hop_itf;
                upd.age        = '0;
                upd.local_mark = r_req.is_local;
                upd_we         = hit;
                upd_chg        = hit && (mem_rdata.cost != r_cost);
            end
            REQ_MERGE: begin
                if (c_plus < {1'b0, mem_rdata.cost}) begin
                    upd.cost       = c_plus[4:0];
                    upd.itf        = r_req.hop_itf;
                    upd.age        = '0;
                    upd.local_mark = 1'b0;
                    upd_we         = hit;
                    upd_chg        = hit;
                end else if (c_plus == {1'b0, mem_rdata.cost}) begin
                    upd.itf = r_req.hop_itf;
                    upd.age = '0;
                    upd_we  = hit;
                end else if (mem_rdata.itf == r_req.hop_itf && r_cost == COST_INF) begin
                    upd.age  = '0;
                    upd.cost = COST_INF;
                    upd_we   = hit;
                    upd_chg  = hit && (mem_rdata.cost != COST_INF);
                end
            end
            REQ_TICK: begin
                if (!mem_rdata.local_mark) begin
                    upd_we = 1'b1;
                    if (aged >= r_timeout) begin
                        upd.cost = COST_INF;
                        upd.age  = '0;
                        upd_chg  = (mem_rdata.cost != COST_INF);
                    end else begin
                        upd.age = aged;
                    end
                end
            end
            default: ;
        endcase
    end

    // append path writes at r_idx == r_count
    t_entry app;
    always_comb begin
        app.address    = r_req.route_address;
        app.itf        = r_req.hop_itf;
        app.age        = '0;
        app.local_mark = (r_req.req_type == REQ_INSTALL) ? r_req.is_local : 1'b0;
        if (r_req.req_type == REQ_INSTALL || r_cost == COST_INF) begin
            app.cost = r_cost;
        end else begin
            app.cost = c_plus[4:0];
        end
    end

    logic eval_done;   // this request finishes on the entry being evaluated
    always_comb begin
        unique case (r_req.req_type)
            REQ_INSTALL, REQ_MERGE: eval_done = hit;
            REQ_LOOKUP:             eval_done = hit && (mem_rdata.cost < COST_INF);
            REQ_TICK, REQ_ADVERTISE: eval_done = is_last_entry;
            default:                eval_done = 1'b1;
        endcase
    end

    assign mem_we    = (r_state == ST_EVAL && upd_we) ||
                       (r_state == ST_APPEND && r_count < MAX_CNT);
    assign mem_wdata = (r_state == ST_APPEND) ? app : upd;

    logic rsp_free;
    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // lookup and advertise emitting from ST_EVAL need a free output
    logic eval_emit;
    assign eval_emit = (r_state == ST_EVAL) &&
        ((r_req.req_type == REQ_ADVERTISE) ||
         (r_req.req_type == REQ_LOOKUP && eval_done));

    logic rsp_load;
    assign rsp_load = (eval_emit || r_state == ST_OUT) && rsp_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_req_valid) n_state = ST_READ;
            ST_READ: begin
                if (r_req.req_type > REQ_ADVERTISE || at_end) begin
                    n_state = (r_req.req_type == REQ_INSTALL ||
                               r_req.req_type == REQ_MERGE) ? ST_APPEND : ST_OUT;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // result pending on a busy output: hold the entry
                if (eval_emit && !rsp_free) begin
                    n_state = ST_EVAL;
                end else if (eval_done) begin
                    n_state = (r_req.req_type == REQ_ADVERTISE ||
                               r_req.req_type == REQ_LOOKUP) ? ST_IDLE : ST_OUT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_APPEND: n_state = ST_OUT;
            ST_OUT:    if (rsp_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // result transaction contents
    always_comb begin
        n_rsp      = '0;
        n_rsp.last = 1'b1;
        if (eval_emit) begin
            if (r_req.req_type == REQ_LOOKUP) begin
                n_rsp.out_cost      = mem_rdata.cost;
                n_rsp.out_interface = mem_rdata.itf;
                n_rsp.found         = 1'b1;
            end else begin
                // poison reverse toward the asking interface
                n_rsp.out_address = mem_rdata.address;
                n_rsp.out_cost    = (mem_rdata.itf == r_req.hop_itf) ?
                                    COST_INF : mem_rdata.cost;
                n_rsp.entry_valid = 1'b1;
                n_rsp.last        = is_last_entry;
            end
        end else begin
            unique case (r_req.req_type)
                REQ_INSTALL, REQ_MERGE: begin
                    n_rsp.table_changed = r_changed;
                    n_rsp.table_full    = !r_changed && (r_idx >= r_count);
                end
                REQ_TICK:   n_rsp.table_changed = r_changed;
                REQ_LOOKUP: n_rsp.out_cost      = COST_INF;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_rsp_valid <= 1'b0;
            r_idx       <= '0;
            r_changed   <= 1'b0;
        end else begin
            if (i_timeout_we) r_timeout <= i_timeout_wdata;
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_idx     <= '0;
                    r_changed <= 1'b0;
                end
                ST_EVAL: begin
                    if (!(eval_emit && !rsp_free)) begin
                        r_changed <= r_changed | upd_chg;
                        if (!eval_done) r_idx <= r_idx + CW'(1);
                    end
                end
                ST_APPEND: begin
                    if (r_count < MAX_CNT) begin
                        r_count   <= r_count + CW'(1);
                        r_changed <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req_valid) begin
            r_req  <= i_req;
            r_cost <= (i_req.advertised_cost > COST_INF) ? COST_INF : i_req.advertised_cost;
        end
        if (rsp_load) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT) else $error("entry count past capacity");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("second transaction taken while busy");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> (r_idx < r_count)) else $error("walk past count");
`endif
endmodule

@@ verif/tb_distance_vector_route_table.sv @@
`timescale 1ns / 1ps
module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int ROUTES    = 64;
    localparam int LIMIT     = 2000000;
    localparam int REQ_BAD   = 5;
    localparam int N_RANDOM  = 420;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_req_valid = 1'b0;
    logic       o_req_ready;
    t_req       i_req = '0;
    logic       o_rsp_valid;
    logic       i_rsp_ready = 1'b0;
    t_rsp       o_rsp;
    logic       i_timeout_we;
    logic [7:0] i_timeout_wdata;

    distance_vector_route_table #(.MAX_ROUTES(ROUTES)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_req          (i_req),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_rsp          (o_rsp),
        .i_timeout_we   (i_timeout_we),
        .i_timeout_wdata(i_timeout_wdata)
    );

    // predicted route table, mirrors the block's state
    logic [31:0] rt_addr  [ROUTES];
    logic [4:0]  rt_cost  [ROUTES];
    logic [3:0]  rt_itf   [ROUTES];
    logic [7:0]  rt_age   [ROUTES];
    logic        rt_local [ROUTES];
    int          rt_count = 0;
    logic [7:0]  rt_timeout = TIMEOUT_RESET;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   cycle_count = 0;
    bit   calm;          // no idling in the last part of the run
    int   send_gap;
    int   recv_gap;

    // address pool keeps hits frequent
    logic [31:0] addr_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input t_rsp got, input t_rsp exp);
        errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
    endtask

    function automatic void queue_rsp(input t_rsp r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    function automatic void queue_req(input t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic t_rsp rsp_zero();
        t_rsp r;
        r = '0;
        return r;
    endfunction

    function automatic int find_route(input logic [31:0] a);
        for (int i = 0; i < rt_count; i++)
            if (rt_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic bit add_route(input logic [31:0] a, input logic [4:0] c,
                                     input logic [3:0] f, input logic l);
        if (rt_count >= ROUTES)
            return 1'b0;
        rt_addr[rt_count]  = a;
        rt_cost[rt_count]  = c;
        rt_itf[rt_count]   = f;
        rt_age[rt_count]   = 8'd0;
        rt_local[rt_count] = l;
        rt_count++;
        return 1'b1;
    endfunction

    // apply one request to the predicted table, queue its results
    task automatic predict_routes(input t_req q);
        t_rsp r;
        logic [4:0] c;
        logic [5:0] c1;
        int k;
        int n;
        r = rsp_zero();
        r.last = 1'b1;
        c = (q.advertised_cost > COST_INF) ? COST_INF : q.advertised_cost;
        c1 = {1'b0, c} + 6'd1;
        case (q.req_type)
            REQ_INSTALL: begin
                k = find_route(q.route_address);
                if (k >= 0) begin
                    r.table_changed = (rt_cost[k] != c);
                    rt_cost[k]  = c;
                    rt_itf[k]   = q.hop_itf;
                    rt_age[k]   = 8'd0;
                    rt_local[k] = q.is_local;
                end else if (add_route(q.route_address, c, q.hop_itf, q.is_local)) begin
                    r.table_changed = 1'b1;
                end else begin
                    r.table_full = 1'b1;
                end
                queue_rsp(r);
            end
            REQ_MERGE: begin
                k = find_route(q.route_address);
                if (k >= 0) begin
                    if (c1 < {1'b0, rt_cost[k]}) begin
                        rt_cost[k]  = c1[4:0];
                        rt_itf[k]   = q.hop_itf;
                        rt_age[k]   = 8'd0;
                        rt_local[k] = 1'b0;
                        r.table_changed = 1'b1;
                    end else if (c1 == {1'b0, rt_cost[k]}) begin
                        rt_itf[k] = q.hop_itf;
                        rt_age[k] = 8'd0;
                    end else if (rt_itf[k] == q.hop_itf && c == COST_INF) begin
                        rt_age[k] = 8'd0;
                        r.table_changed = (rt_cost[k] != COST_INF);
                        rt_cost[k] = COST_INF;
                    end
                end else if (add_route(q.route_address, (c == COST_INF) ? COST_INF : c1[4:0],
                                       q.hop_itf, 1'b0)) begin
                    r.table_changed = 1'b1;
                end else begin
                    r.table_full = 1'b1;
                end
                queue_rsp(r);
            end
            REQ_TICK: begin
                for (int i = 0; i < rt_count; i++) begin
                    if (!rt_local[i]) begin
                        if (rt_age[i] < AGE_MAX)
                            rt_age[i]++;
                        if (rt_age[i] >= rt_timeout) begin
                            if (rt_cost[i] != COST_INF)
                                r.table_changed = 1'b1;
                            rt_cost[i] = COST_INF;
                            rt_age[i]  = 8'd0;
                        end
                    end
                end
                queue_rsp(r);
            end
            REQ_LOOKUP: begin
                r.out_cost = COST_INF;
                for (int i = 0; i < rt_count; i++) begin
                    if (rt_addr[i] == q.route_address && rt_cost[i] < COST_INF) begin
                        r.out_cost      = rt_cost[i];
                        r.out_interface = rt_itf[i];
                        r.found         = 1'b1;
                        break;
                    end
                end
                queue_rsp(r);
            end
            REQ_ADVERTISE: begin
                n = rt_count;
                if (n == 0)
                    queue_rsp(r);
                for (int i = 0; i < n; i++) begin
                    r = rsp_zero();
                    r.out_address = rt_addr[i];
                    // poison reverse toward the asking interface
                    r.out_cost    = (rt_itf[i] == q.hop_itf) ? COST_INF : rt_cost[i];
                    r.entry_valid = 1'b1;
                    r.last        = (i == n - 1);
                    queue_rsp(r);
                end
            end
            default: queue_rsp(r);
        endcase
    endtask

    function automatic t_req make_req(input logic [2:0] kind, input logic [31:0] a,
                                      input logic [4:0] c, input logic [3:0] f,
                                      input logic l);
        t_req q;
        q.req_type        = kind;
        q.route_address   = a;
        q.advertised_cost = c;
        q.hop_itf         = f;
        q.is_local        = l;
        return q;
    endfunction

    // random request, weighted toward table-building
    function automatic t_req random_req();
        int sel;
        logic [2:0] kind;
        logic [31:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 22)       kind = REQ_INSTALL;
        else if (sel < 55)  kind = REQ_MERGE;
        else if (sel < 72)  kind = REQ_TICK;
        else if (sel < 90)  kind = REQ_LOOKUP;
        else if (sel < 96)  kind = REQ_ADVERTISE;
        else                kind = 3'($urandom_range(REQ_BAD, 7));
        a = ($urandom_range(0, 3) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
        return make_req(kind, a,
                        ($urandom_range(0, 5) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 16)),
                        4'($urandom()), ($urandom_range(0, 4) == 0));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        // all results are in; let the sequencer settle
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        @(posedge i_clk);
        i_timeout_we    <= 1'b1;
        i_timeout_wdata <= v;
        @(posedge i_clk);
        i_timeout_we    <= 1'b0;
        rt_timeout = v;
    endtask

    // driver: pops the next request, holds it until the handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            send_gap    <= 0;
        end else if (!i_req_valid || o_req_ready) begin
            if (send_gap > 0) begin
                i_req_valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                i_req       <= pending_reqs[0];
                i_req_valid <= 1'b1;
                predict_routes(pending_reqs.pop_front());
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 8);
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction, throttles ready in bursts
    always @(posedge i_clk) begin
        t_rsp exp;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", o_rsp, rsp_zero());
                end else begin
                    exp = expected_rsps.pop_front();
                    if (o_rsp.out_address !== exp.out_address)
                        report_mismatch("out_address", o_rsp, exp);
                    if (o_rsp.out_cost !== exp.out_cost)
                        report_mismatch("out_cost", o_rsp, exp);
                    if (o_rsp.out_interface !== exp.out_interface)
                        report_mismatch("out_interface", o_rsp, exp);
                    if (o_rsp.found !== exp.found)
                        report_mismatch("found", o_rsp, exp);
                    if (o_rsp.entry_valid !== exp.entry_valid)
                        report_mismatch("entry_valid", o_rsp, exp);
                    if (o_rsp.table_changed !== exp.table_changed)
                        report_mismatch("table_changed", o_rsp, exp);
                    if (o_rsp.table_full !== exp.table_full)
                        report_mismatch("table_full", o_rsp, exp);
                    if (o_rsp.last !== exp.last)
                        report_mismatch("last", o_rsp, exp);
                end
            end
            if (recv_gap > 0) begin
                i_rsp_ready <= 1'b0;
                recv_gap    <= recv_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_rsp_ready <= 1'b0;
                recv_gap    <= $urandom_range(0, 7);
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("distance_vector_route_table verification failed");
            $finish;
        end
    end

    initial begin
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_timeout_we    = 1'b0;
        i_timeout_wdata = 8'd0;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, every request kind
        queue_req(make_req(REQ_ADVERTISE, 32'h0, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_INSTALL, 32'h0, 5'd0, 4'd15, 1'b1));
        queue_req(make_req(REQ_INSTALL, 32'hFFFF_FFFF, 5'd31, 4'd0, 1'b0));
        queue_req(make_req(REQ_INSTALL, 32'hFFFF_FFFF, 5'd3, 4'd7, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'hFFFF_FFFF, 5'd1, 4'd9, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'hFFFF_FFFF, 5'd1, 4'd4, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'hFFFF_FFFF, 5'd20, 4'd4, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'hA5A5_5A5A, 5'd16, 4'd2, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'h1234_5678, 5'd15, 4'd2, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'h1234_5678, 5'd0, 4'd3, 1'b0));
        queue_req(make_req(REQ_LOOKUP, 32'h1234_5678, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_LOOKUP, 32'hA5A5_5A5A, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_ADVERTISE, 32'h0, 5'd0, 4'd3, 1'b0));
        queue_req(make_req(REQ_TICK, 32'h0, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(3'd5, 32'hFFFF_FFFF, 5'd31, 4'd15, 1'b1));
        queue_req(make_req(3'd7, 32'h0, 5'd0, 4'd0, 1'b0));
        wait_drained();

        // shortest timeout, then zero: everything non-local ages out
        write_timeout(8'd1);
        queue_req(make_req(REQ_TICK, 32'h0, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_MERGE, 32'h1234_5678, 5'd2, 4'd1, 1'b0));
        wait_drained();
        write_timeout(8'd0);
        queue_req(make_req(REQ_TICK, 32'h0, 5'd0, 4'd0, 1'b0));
        queue_req(make_req(REQ_ADVERTISE, 32'h0, 5'd0, 4'd1, 1'b0));
        wait_drained();

        // random phases across timeout settings, table fills up over time
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_timeout(8'd255);
                1: write_timeout(8'd3);
                2: write_timeout(8'($urandom_range(1, 20)));
                3: write_timeout(8'd12);
                default: write_timeout(8'd6);
            endcase
            if (ph == 4)
                calm = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++)
                queue_req(random_req());
            // fill the table with fresh addresses to hit the full case
            if (ph == 2)
                for (int n = 0; n < 70; n++)
                    queue_req(make_req(($urandom_range(0, 1) != 0) ? REQ_INSTALL
                                       : REQ_MERGE, $urandom(),
                                       5'($urandom_range(0, 16)),
                                       4'($urandom()), 1'b0));
            wait_drained();
        end

        if (errors == 0) begin
            $display("distance_vector_route_table verification clean");
        end else begin
            $display("distance_vector_route_table verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/dvrt_pkg.sv
rtl/core/dvrt_mem.sv
rtl/core/distance_vector_route_table.sv
verif/tb_distance_vector_route_table.sv
